// ===== src/tpi_pkg.sv =====
package tpi_pkg;

  typedef struct packed {
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
    logic               last_point;
  } point_t;

  typedef struct packed {
    logic signed [15:0] route_x;
    logic signed [15:0] route_y;
    logic               route_last;
    logic [30:0]        old_length;
    logic [30:0]        new_length;
    logic               points_dropped;
  } route_t;

  localparam logic [30:0] LEN_MAX = 31'h7FFF_FFFF;

endpackage

// ===== src/two_opt_path_improver.sv =====
// Points load at one word per cycle; busy rises after the word marked last.
// Edge lengths come from a square root (RW = 18+FRACTION_BITS, one root bit per cycle);
// a path length sums the neighbour edges; a 2-opt pair compares its current edges with the reconnected ones.
// A reversal swaps each pair via S_RV_A, S_RV_B, S_RV_W1 and S_RV_W2. Results pass the memory
// read and pend registers, then stream one word per cycle, since the receiver cannot stall.
// Synchronous reset empties the path and returns to loading; the point memory is not cleared.
module two_opt_path_improver #(
  parameter int MAX_POINTS    = 64,
  parameter int FRACTION_BITS = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  tpi_pkg::point_t point,
  output logic            route_valid,
  output tpi_pkg::route_t route
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int RW = 18 + FRACTION_BITS;
  localparam int VW = 2 * RW;
  localparam int SW = $clog2(RW + 1);

  localparam logic [3:0] S_LOAD     = 4'd0;
  localparam logic [3:0] S_RD_A     = 4'd1;
  localparam logic [3:0] S_RD_B     = 4'd2;
  localparam logic [3:0] S_WT       = 4'd3;
  localparam logic [3:0] S_SQ       = 4'd4;
  localparam logic [3:0] S_SUM      = 4'd5;
  localparam logic [3:0] S_SQRT     = 4'd6;
  localparam logic [3:0] S_EDONE    = 4'd7;
  localparam logic [3:0] S_LEN_NEXT = 4'd8;
  localparam logic [3:0] S_PAIR     = 4'd9;
  localparam logic [3:0] S_RV_A     = 4'd10;
  localparam logic [3:0] S_RV_B     = 4'd11;
  localparam logic [3:0] S_RV_W1    = 4'd12;
  localparam logic [3:0] S_RV_W2    = 4'd13;
  localparam logic [3:0] S_OUT      = 4'd14;
  localparam logic [3:0] S_OUT_END  = 4'd15;

  logic [3:0]        state;
  logic [CW-1:0]     count;
  logic [CW-1:0]     n;
  logic              ovf;
  logic              pass2;
  logic              in_pair;
  logic [1:0]        ps;
  logic [AW-1:0]     a, b;
  logic [AW-1:0]     i, j, lo, hi;
  logic [CW-1:0]     k;
  logic [CW-1:0]     oc;
  logic [AW-1:0]     pk;
  logic              pend;
  logic [31:0]       pa, pb, plo;
  logic [32:0]       sx, sy;
  logic [VW-1:0]     src;
  logic [RW:0]       rem;
  logic [RW-1:0]     root;
  logic [SW-1:0]     scnt;
  logic [30:0]       acc, orig, newlen;
  logic [RW:0]       cur, alt;

  logic [31:0]       mem [MAX_POINTS];
  logic [31:0]       rdata;
  logic              we;
  logic [AW-1:0]     waddr, raddr;
  logic [31:0]       wdata;

  logic              accept;
  logic              room;
  logic signed [16:0] dx, dy;
  logic [RW+2:0]     sq_tmp, sq_trial;
  logic [31:0]       acc_sum;
  logic [30:0]       acc_sat;
  logic [RW:0]       alt_sum;
  logic              i_done, j_done;

  assign accept = start && !busy;
  assign room   = count < CW'(MAX_POINTS);
  assign busy   = state != S_LOAD;

  assign dx = $signed({pa[31], pa[31:16]}) - $signed({pb[31], pb[31:16]});
  assign dy = $signed({pa[15], pa[15:0]}) - $signed({pb[15], pb[15:0]});

  assign sq_tmp   = {rem, src[VW-1 -: 2]};
  assign sq_trial = {1'b0, root, 2'b01};

  assign acc_sum = {1'b0, acc} + 32'(root);
  assign acc_sat = (acc_sum > {1'b0, tpi_pkg::LEN_MAX}) ? tpi_pkg::LEN_MAX : acc_sum[30:0];
  assign alt_sum = alt + (RW+1)'(root);

  assign i_done = ((CW+1)'(i) + (CW+1)'(5)) > {1'b0, n};
  assign j_done = ((CW+1)'(j) + (CW+1)'(1)) >= {1'b0, n};

  always_comb begin
    we    = 1'b0;
    waddr = count[AW-1:0];
    wdata = {point.coord_x, point.coord_y};
    raddr = a;
    unique case (state)
      S_LOAD: begin
        we = accept && room;
      end
      S_RD_B: raddr = b;
      S_RV_A: raddr = lo;
      S_RV_B: raddr = hi;
      S_RV_W1: begin
        we    = 1'b1;
        waddr = lo;
        wdata = rdata;
      end
      S_RV_W2: begin
        we    = 1'b1;
        waddr = hi;
        wdata = plo;
      end
      S_OUT: raddr = oc[AW-1:0];
      default: raddr = a;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_LOAD;
      count       <= '0;
      ovf         <= 1'b0;
      pend        <= 1'b0;
      route_valid <= 1'b0;
    end else begin
      pend        <= (state == S_OUT);
      route_valid <= pend;
      if (pend) begin
        route.route_x        <= rdata[31:16];
        route.route_y        <= rdata[15:0];
        route.route_last     <= (CW'(pk) + CW'(1)) == n;
        route.old_length     <= orig;
        route.new_length     <= newlen;
        route.points_dropped <= ovf;
      end
      unique case (state)
        S_LOAD: begin
          if (accept) begin
            if (room) count <= count + CW'(1);
            else ovf <= 1'b1;
            if (point.last_point) begin
              n       <= room ? count + CW'(1) : count;
              pass2   <= 1'b0;
              in_pair <= 1'b0;
              acc     <= '0;
              k       <= '0;
              state   <= S_LEN_NEXT;
            end
          end
        end
        S_RD_A: state <= S_RD_B;
        S_RD_B: begin
          pa    <= rdata;
          state <= S_WT;
        end
        S_WT: begin
          pb    <= rdata;
          state <= S_SQ;
        end
        S_SQ: begin
          sx    <= 33'(dx * dx);
          sy    <= 33'(dy * dy);
          state <= S_SUM;
        end
        S_SUM: begin
          src   <= VW'({1'b0, sx} + {1'b0, sy}) << (2 * FRACTION_BITS);
          rem   <= '0;
          root  <= '0;
          scnt  <= '0;
          state <= S_SQRT;
        end
        S_SQRT: begin
          // Digit-by-digit square root, one result bit per cycle.
          if (sq_tmp >= sq_trial) begin
            rem  <= (RW+1)'(sq_tmp - sq_trial);
            root <= {root[RW-2:0], 1'b1};
          end else begin
            rem  <= (RW+1)'(sq_tmp);
            root <= {root[RW-2:0], 1'b0};
          end
          src  <= src << 2;
          scnt <= scnt + SW'(1);
          if (scnt == SW'(RW - 1)) state <= S_EDONE;
        end
        S_EDONE: begin
          if (!in_pair) begin
            acc   <= acc_sat;
            k     <= k + CW'(1);
            state <= S_LEN_NEXT;
          end else begin
            ps <= ps + 2'd1;
            unique case (ps)
              2'd0: begin
                cur   <= (RW+1)'(root);
                a     <= j;
                b     <= j + AW'(1);
                state <= S_RD_A;
              end
              2'd1: begin
                cur   <= cur + (RW+1)'(root);
                a     <= i;
                b     <= j;
                state <= S_RD_A;
              end
              2'd2: begin
                alt   <= (RW+1)'(root);
                a     <= i + AW'(1);
                b     <= j + AW'(1);
                state <= S_RD_A;
              end
              default: begin
                if (alt_sum < cur) begin
                  lo    <= i + AW'(1);
                  hi    <= j;
                  state <= S_RV_A;
                end else begin
                  j     <= j + AW'(1);
                  state <= S_PAIR;
                end
              end
            endcase
          end
        end
        S_LEN_NEXT: begin
          if ((k + CW'(1)) < n) begin
            a     <= k[AW-1:0];
            b     <= AW'(k + CW'(1));
            state <= S_RD_A;
          end else if (!pass2) begin
            orig    <= acc;
            in_pair <= 1'b1;
            i       <= '0;
            j       <= AW'(3);
            state   <= S_PAIR;
          end else begin
            newlen <= acc;
            oc     <= '0;
            state  <= S_OUT;
          end
        end
        S_PAIR: begin
          if (i_done) begin
            in_pair <= 1'b0;
            pass2   <= 1'b1;
            acc     <= '0;
            k       <= '0;
            state   <= S_LEN_NEXT;
          end else if (j_done) begin
            i <= i + AW'(1);
            j <= i + AW'(4);
          end else begin
            ps    <= 2'd0;
            a     <= i;
            b     <= i + AW'(1);
            state <= S_RD_A;
          end
        end
        S_RV_A: state <= S_RV_B;
        S_RV_B: begin
          plo   <= rdata;
          state <= S_RV_W1;
        end
        S_RV_W1: state <= S_RV_W2;
        S_RV_W2: begin
          lo <= lo + AW'(1);
          hi <= hi - AW'(1);
          if ((lo + AW'(1)) < (hi - AW'(1))) begin
            state <= S_RV_A;
          end else begin
            // An improvement restarts the scan from the first edge.
            i     <= '0;
            j     <= AW'(3);
            state <= S_PAIR;
          end
        end
        S_OUT: begin
          pk <= oc[AW-1:0];
          oc <= oc + CW'(1);
          if ((oc + CW'(1)) == n) state <= S_OUT_END;
        end
        default: begin
          count <= '0;
          ovf   <= 1'b0;
          state <= S_LOAD;
        end
      endcase
    end
  end

  a_busy_after_last: assert property (@(posedge clk) disable iff (rst)
    start && !busy && point.last_point |=> busy)
    else $error("busy did not rise after the last point word");

  a_stream: assert property (@(posedge clk) disable iff (rst)
    route_valid && !route.route_last |=> route_valid)
    else $error("gap in the result stream");

  a_end: assert property (@(posedge clk) disable iff (rst)
    route_valid && route.route_last |=> !route_valid)
    else $error("result word after the last route point");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    route_valid && !route.route_last |-> busy)
    else $error("input accepted while results still streaming");

endmodule
